### rtl/core/ookpd_pkg.sv
// Package with the word types, register indexes and constants of the OOK frame encoder.
package ookpd_pkg;

    localparam int FRAME_LEN = 36;
    localparam logic [3:0] SYNC_LEN = 4'd9;
    localparam logic [3:0] BIT0_LEN = 4'd3;
    localparam logic [3:0] ONE_LEN = 4'd5;
    localparam logic [3:0] CHANNEL_OFFSET = 4'd7;
    localparam logic [3:0] FIXED_NIBBLE = 4'hF;

    localparam logic [3:0] REPEAT_COUNT_RESET = 4'd12;
    localparam logic [15:0] SAMPLES_PER_SYMBOL_RESET = 16'd1000;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_COUNT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLES_PER_SYMBOL = 1'd1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic              op;
        logic [7:0]        sensor_id;
        logic [3:0]        channel;
        logic signed [11:0] temp_tenths;
        logic [7:0]        humidity;
    } in_word_t;

    typedef struct packed {
        logic level;
        logic active;
        logic last;
    } out_word_t;

endpackage

### rtl/core/ook_pulse_distance_frame_encoder.sv
// Top level of the OOK pulse-distance frame encoder for a weather sensor frame.
//
// Usage: the input channel carries words of two kinds. A load word (op 0) packs a
// 36-bit frame from sensor_id, channel, temp_tenths and humidity and restarts the
// transmission from the sync of the first repeat; it gives no result. A tick word
// (op 1) stands for one output sample and gives exactly one result word with the
// keying level, an active flag and a last flag on the final sample of the final
// repeat. Idle ticks give level 0 with active and last low.
// The two registers (repeat_count, samples_per_symbol) are written through the
// write port; the user is to write them only when the block is idle, as the block
// itself does not enforce it. Zero in either is treated as one. A tick's result is
// registered in the output buffer. Throughput: one word per cycle while in_ready
// is high; the state update is a single registered pass.
// Reset clears the sequencer to idle, empties the output buffer and loads the
// register defaults (12 repeats, 1000 samples per symbol).
// When the receiver stalls, a second result is held in a skid entry; in_ready
// drops only while both output entries are full.
module ook_pulse_distance_frame_encoder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  ookpd_pkg::in_word_t                 in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output ookpd_pkg::out_word_t                out_data,
    input  logic                                cfg_we,
    input  logic [ookpd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ookpd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [3:0]  repeat_count_reg;
    logic [15:0] samples_per_symbol_reg;

    logic [35:0] frame_bits_reg;
    logic [35:0] frame_bits_next;
    logic [3:0]  repeat_index_reg;
    logic [3:0]  repeat_index_next;
    logic [5:0]  bit_index_reg;
    logic [5:0]  bit_index_next;
    logic [3:0]  symbol_position_reg;
    logic [3:0]  symbol_position_next;
    logic [15:0] sample_counter_reg;
    logic [15:0] sample_counter_next;
    logic        in_sync_reg;
    logic        in_sync_next;
    logic        busy_reg;
    logic        busy_next;

    logic                 accept;
    logic                 push_valid;
    ookpd_pkg::out_word_t push_word;
    logic [16:0]          sps;
    logic [4:0]           reps;
    logic [5:0]           bit_pos;
    logic                 current_bit;
    logic [3:0]           group_len;
    logic [3:0]           channel_nibble;

    assign accept = in_valid && in_ready;
    assign sps = (samples_per_symbol_reg == 16'd0) ? 17'd1 : {1'b0, samples_per_symbol_reg};
    assign reps = (repeat_count_reg == 4'd0) ? 5'd1 : {1'b0, repeat_count_reg};
    assign bit_pos = 6'(ookpd_pkg::FRAME_LEN - 1) - bit_index_reg;
    assign current_bit = (bit_index_reg < 6'(ookpd_pkg::FRAME_LEN)) ?
                         frame_bits_reg[bit_pos] : 1'b0;
    assign group_len = in_sync_reg ? ookpd_pkg::SYNC_LEN :
                       (current_bit ? ookpd_pkg::ONE_LEN : ookpd_pkg::BIT0_LEN);
    assign channel_nibble = in_data.channel + ookpd_pkg::CHANNEL_OFFSET;

    always_comb
    begin
        frame_bits_next = frame_bits_reg;
        repeat_index_next = repeat_index_reg;
        bit_index_next = bit_index_reg;
        symbol_position_next = symbol_position_reg;
        sample_counter_next = sample_counter_reg;
        in_sync_next = in_sync_reg;
        busy_next = busy_reg;
        push_valid = 1'b0;
        push_word = '0;
        if (accept)
        begin
            if (in_data.op == ookpd_pkg::OP_LOAD)
            begin
                frame_bits_next = {in_data.sensor_id, channel_nibble,
                                   in_data.temp_tenths, ookpd_pkg::FIXED_NIBBLE,
                                   in_data.humidity};
                repeat_index_next = 4'd0;
                bit_index_next = 6'd0;
                symbol_position_next = 4'd0;
                sample_counter_next = 16'd0;
                in_sync_next = 1'b1;
                busy_next = 1'b1;
            end
            else
            begin
                push_valid = 1'b1;
                if (busy_reg)
                begin
                    push_word.level = (symbol_position_reg == 4'd0);
                    push_word.active = 1'b1;
                    if ({1'b0, sample_counter_reg} + 17'd1 >= sps)
                    begin
                        sample_counter_next = 16'd0;
                        if (symbol_position_reg + 4'd1 >= group_len)
                        begin
                            symbol_position_next = 4'd0;
                            if (in_sync_reg)
                            begin
                                in_sync_next = 1'b0;
                                bit_index_next = 6'd0;
                            end
                            else if (bit_index_reg + 6'd1 >= 6'(ookpd_pkg::FRAME_LEN))
                            begin
                                bit_index_next = 6'd0;
                                if ({1'b0, repeat_index_reg} + 5'd1 >= reps)
                                begin
                                    busy_next = 1'b0;
                                    repeat_index_next = 4'd0;
                                    push_word.last = 1'b1;
                                end
                                else
                                begin
                                    repeat_index_next = repeat_index_reg + 4'd1;
                                    in_sync_next = 1'b1;
                                end
                            end
                            else
                            begin
                                bit_index_next = bit_index_reg + 6'd1;
                            end
                        end
                        else
                        begin
                            symbol_position_next = symbol_position_reg + 4'd1;
                        end
                    end
                    else
                    begin
                        sample_counter_next = sample_counter_reg + 16'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_count_reg <= ookpd_pkg::REPEAT_COUNT_RESET;
            samples_per_symbol_reg <= ookpd_pkg::SAMPLES_PER_SYMBOL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ookpd_pkg::CFG_REPEAT_COUNT: repeat_count_reg <= cfg_data[3:0];
                ookpd_pkg::CFG_SAMPLES_PER_SYMBOL: samples_per_symbol_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_bits_reg <= '0;
            repeat_index_reg <= 4'd0;
            bit_index_reg <= 6'd0;
            symbol_position_reg <= 4'd0;
            sample_counter_reg <= 16'd0;
            in_sync_reg <= 1'b0;
            busy_reg <= 1'b0;
        end
        else
        begin
            frame_bits_reg <= frame_bits_next;
            repeat_index_reg <= repeat_index_next;
            bit_index_reg <= bit_index_next;
            symbol_position_reg <= symbol_position_next;
            sample_counter_reg <= sample_counter_next;
            in_sync_reg <= in_sync_next;
            busy_reg <= busy_next;
        end
    end

    ookpd_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_word  (push_word),
        .push_ready (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

### rtl/core/ookpd_out_buf.sv
// Two-entry output buffer that holds result words while the receiver stalls.
module ookpd_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    input  ookpd_pkg::out_word_t push_word,
    output logic                push_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output ookpd_pkg::out_word_t out_data
);

    logic                 main_valid_reg;
    logic                 main_valid_next;
    ookpd_pkg::out_word_t main_word_reg;
    ookpd_pkg::out_word_t main_word_next;
    logic                 skid_valid_reg;
    logic                 skid_valid_next;
    ookpd_pkg::out_word_t skid_word_reg;
    ookpd_pkg::out_word_t skid_word_next;

    assign push_ready = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data = main_word_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_word_next = main_word_reg;
        skid_valid_next = skid_valid_reg;
        skid_word_next = skid_word_reg;
        if (main_valid_reg && !out_ready)
        begin
            if (push_valid && !skid_valid_reg)
            begin
                skid_valid_next = 1'b1;
                skid_word_next = push_word;
            end
        end
        else if (skid_valid_reg)
        begin
            main_valid_next = 1'b1;
            main_word_next = skid_word_reg;
            skid_valid_next = 1'b0;
        end
        else
        begin
            main_valid_next = push_valid;
            main_word_next = push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_word_reg <= main_word_next;
        skid_word_reg <= skid_word_next;
    end

endmodule

### rtl/core/ookpd_checker.sv
// Port-level checker for the OOK frame encoder, bound to the top level.
module ookpd_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_ready,
    input ookpd_pkg::out_word_t out_data
);

    assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("Output word shown during reset.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("Stalled output word changed or dropped.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.last |-> out_data.active)
        else $error("Last flag set on an idle sample.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.active |-> !out_data.level && !out_data.last)
        else $error("Idle sample carries a level or last flag.");

endmodule

bind ook_pulse_distance_frame_encoder ookpd_checker u_ookpd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

### tb/tb.sv
// Self-checking testbench for the OOK pulse-distance frame encoder.
`timescale 1ns / 1ps

module tb;
    import ookpd_pkg::*;

    localparam int RANDOM_WORDS = 300;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS = 40;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_word_t in_data;
    logic out_valid;
    logic out_ready;
    out_word_t out_data;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ook_pulse_distance_frame_encoder dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Encoder state as the testbench expects it.
    logic [3:0] repeats_cfg;
    logic [15:0] sps_cfg;
    logic [FRAME_LEN-1:0] frame_reg;
    logic [3:0] repeat_num;
    logic [5:0] bit_pos;
    logic [3:0] symbol_step;
    logic [15:0] sample_in_symbol;
    logic sync_phase;
    logic sending;

    out_word_t expected_samples[$];

    int mismatches = 0;
    int words_sent = 0;
    int loads_sent = 0;
    int results_checked = 0;
    int frames_done = 0;
    int reg_writes = 0;
    int input_stalls = 0;
    int burst_left = 1;
    bit offering = 1'b0;
    bit hold_request = 1'b0;
    int hold_left = 0;
    int rx_cycle = 0;
    int quiet_cycles;

    function automatic void load_frame(input in_word_t w);
        logic [3:0] ch_nibble;
        ch_nibble = w.channel + CHANNEL_OFFSET;
        frame_reg = {w.sensor_id, ch_nibble, w.temp_tenths, FIXED_NIBBLE, w.humidity};
        repeat_num = '0;
        bit_pos = '0;
        symbol_step = '0;
        sample_in_symbol = '0;
        sync_phase = 1'b1;
        sending = 1'b1;
    endfunction

    function automatic out_word_t keying_sample();
        out_word_t s;
        int unsigned span;
        int unsigned reps;
        int unsigned group;
        s = '0;
        if (!sending)
            return s;
        span = (sps_cfg == 0) ? 1 : sps_cfg;
        reps = (repeats_cfg == 0) ? 1 : repeats_cfg;
        s.active = 1'b1;
        s.level = (symbol_step == 0);
        if (sample_in_symbol + 1 >= span)
        begin
            sample_in_symbol = '0;
            if (sync_phase)
                group = SYNC_LEN;
            else if (bit_pos < FRAME_LEN && frame_reg[FRAME_LEN-1-bit_pos])
                group = ONE_LEN;
            else
                group = BIT0_LEN;
            if (symbol_step + 1 >= group)
            begin
                symbol_step = '0;
                if (sync_phase)
                begin
                    sync_phase = 1'b0;
                    bit_pos = '0;
                end
                else
                begin
                    bit_pos++;
                    if (bit_pos >= FRAME_LEN)
                    begin
                        bit_pos = '0;
                        if (repeat_num + 1 >= reps)
                        begin
                            sending = 1'b0;
                            repeat_num = '0;
                            s.last = 1'b1;
                        end
                        else
                        begin
                            repeat_num++;
                            sync_phase = 1'b1;
                        end
                    end
                end
            end
            else
            begin
                symbol_step++;
            end
        end
        else
        begin
            sample_in_symbol++;
        end
        return s;
    endfunction

    function automatic in_word_t random_word(input logic op);
        in_word_t w;
        w.op = op;
        w.sensor_id = 8'($urandom);
        w.channel = 4'($urandom);
        w.temp_tenths = 12'($urandom);
        w.humidity = 8'($urandom);
        return w;
    endfunction

    function automatic in_word_t make_load(input logic [7:0] id, input logic [3:0] ch,
                                           input logic [11:0] temp, input logic [7:0] hum);
        in_word_t w;
        w.op = OP_LOAD;
        w.sensor_id = id;
        w.channel = ch;
        w.temp_tenths = temp;
        w.humidity = hum;
        return w;
    endfunction

    function automatic void compare_bit(input string field, input logic expv, input logic gotv);
        if (gotv !== expv)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0b, got %0b", $time, field, expv, gotv);
        end
    endfunction

    task automatic send_word(input in_word_t w);
        out_word_t sample;
        in_data <= w;
        if (!offering)
        begin
            in_valid <= 1'b1;
            offering = 1'b1;
        end
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
        if (w.op == OP_LOAD)
        begin
            loads_sent++;
            load_frame(w);
        end
        else
        begin
            sample = keying_sample();
            expected_samples.insert(expected_samples.size(), sample);
        end
        burst_left--;
        if (burst_left <= 0)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 48);
        end
    endtask

    task automatic send_tick();
        send_word(random_word(OP_TICK));
    endtask

    task automatic drain_and_pause();
        if (offering)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
        end
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        reg_writes++;
        if (idx == CFG_REPEAT_COUNT)
            repeats_cfg = value[3:0];
        else
            sps_cfg = value;
        @(posedge clk);
    endtask

    task automatic test_idle_after_reset();
        repeat (3) send_tick();
        send_word(random_word(OP_LOAD));
        repeat (5) send_tick();
    endtask

    task automatic test_field_extremes();
        drain_and_pause();
        write_reg(CFG_REPEAT_COUNT, 16'd1);
        write_reg(CFG_SAMPLES_PER_SYMBOL, 16'd1);
        send_word(make_load(8'hFF, 4'd0, 12'h800, 8'h00));
        repeat (2) send_tick();
        send_word(make_load(8'h00, 4'd8, 12'h7FF, 8'hFF));
        repeat (2) send_tick();
        send_word(make_load(8'hA5, 4'd9, 12'hFFF, 8'h5A));
        repeat (2) send_tick();
        send_word(make_load(8'h5A, 4'd15, 12'h000, 8'hA5));
        repeat (2) send_tick();
    endtask

    task automatic test_zero_config();
        drain_and_pause();
        write_reg(CFG_REPEAT_COUNT, 16'd0);
        write_reg(CFG_SAMPLES_PER_SYMBOL, 16'd0);
        send_word(random_word(OP_LOAD));
        while (sending)
            send_tick();
        repeat (3) send_tick();
    endtask

    task automatic test_random_frames();
        int start;
        start = words_sent;
        while (words_sent - start < RANDOM_WORDS)
        begin
            drain_and_pause();
            write_reg(CFG_REPEAT_COUNT, {12'($urandom), 4'($urandom_range(0, 3))});
            write_reg(CFG_SAMPLES_PER_SYMBOL, 16'($urandom_range(0, 2)));
            repeat ($urandom_range(2, 4))
            begin
                if ($urandom_range(0, 4) != 0)
                begin
                    send_word(random_word(OP_LOAD));
                    if ($urandom_range(0, 3) == 0)
                    begin
                        repeat ($urandom_range(1, 120)) send_tick();
                    end
                    else
                    begin
                        while (sending && words_sent - start < RANDOM_WORDS)
                            send_tick();
                    end
                    repeat ($urandom_range(0, 4)) send_tick();
                end
                else
                begin
                    repeat ($urandom_range(1, 12))
                        send_word(random_word(($urandom_range(0, 3) == 0) ? OP_LOAD : OP_TICK));
                end
            end
        end
    endtask

    task automatic test_max_repeats();
        drain_and_pause();
        write_reg(CFG_REPEAT_COUNT, {12'($urandom), 4'hF});
        write_reg(CFG_SAMPLES_PER_SYMBOL, 16'd1);
        send_word(make_load(8'h00, 4'd9, 12'h000, 8'h00));
        repeat (160) send_tick();
    endtask

    task automatic test_midframe_config();
        drain_and_pause();
        write_reg(CFG_REPEAT_COUNT, 16'd15);
        write_reg(CFG_SAMPLES_PER_SYMBOL, 16'hFFFF);
        send_word(random_word(OP_LOAD));
        repeat (40) send_tick();
        drain_and_pause();
        write_reg(CFG_SAMPLES_PER_SYMBOL, 16'd1);
        repeat (200) send_tick();
        drain_and_pause();
        write_reg(CFG_REPEAT_COUNT, 16'd1);
        while (sending)
            send_tick();
        repeat (2) send_tick();
    endtask

    task automatic test_backpressure();
        drain_and_pause();
        write_reg(CFG_REPEAT_COUNT, 16'd2);
        write_reg(CFG_SAMPLES_PER_SYMBOL, 16'd1);
        hold_request = 1'b1;
        send_word(random_word(OP_LOAD));
        while (sending)
            send_tick();
        repeat (3) send_tick();
    endtask

    // The receiver cycles through its own stall patterns, with one long hold-off on request.
    always @(posedge clk)
    begin
        rx_cycle++;
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            case ((rx_cycle / 50) % 4)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 1) == 1);
                2: out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= (rx_cycle % 3 != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_samples.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result word with nothing expected, expected none, got %b",
                             $time, out_data);
            end
            else
            begin
                out_word_t exp_word;
                exp_word = expected_samples.pop_front();
                compare_bit("level", exp_word.level, out_data.level);
                compare_bit("active", exp_word.active, out_data.active);
                compare_bit("last", exp_word.last, out_data.last);
                results_checked++;
                if (exp_word.last)
                    frames_done++;
            end
        end
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (in_valid && !in_ready)
                input_stalls++;
        end
        $display("Timeout: no word moved for %0d cycles.", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeats_cfg = REPEAT_COUNT_RESET;
        sps_cfg = SAMPLES_PER_SYMBOL_RESET;
        frame_reg = '0;
        repeat_num = '0;
        bit_pos = '0;
        symbol_step = '0;
        sample_in_symbol = '0;
        sync_phase = 1'b0;
        sending = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_after_reset();
        test_field_extremes();
        test_zero_config();
        test_random_frames();
        test_max_repeats();
        test_midframe_config();
        test_backpressure();

        drain_and_pause();
        repeat (8) @(posedge clk);
        $display("Sent %0d words (%0d frame loads) and checked %0d result words,",
                 words_sent, loads_sent, results_checked);
        $display("%0d complete transmissions, %0d register writes, %0d input stall cycles.",
                 frames_done, reg_writes, input_stalls);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### files.f
rtl/core/ookpd_pkg.sv
rtl/core/ookpd_out_buf.sv
rtl/core/ook_pulse_distance_frame_encoder.sv
rtl/core/ookpd_checker.sv
tb/tb.sv
